// ----- src/assert_macros.svh -----
// assertion helpers for the file that checks internal behavior
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define LANT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true at a clock edge outside reset
`define LANT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- src/lant_pkg.sv -----
// ----------------------------------------------------------------------------
// lant_pkg
// Types and constants for the multi-ant toroidal grid stepper.
// ----------------------------------------------------------------------------
package lant_pkg;

    // grid and ant table geometry
    localparam int MAX_COLS    = 256;
    localparam int MAX_ROWS    = 256;
    localparam int NUM_ANTS    = 16;
    localparam int MAX_GENS    = 4;
    localparam int COL_W       = 8;
    localparam int ROW_W       = 8;
    localparam int ANT_W       = 4;
    localparam int HEAD_W      = 2;

    // remainder unit step counter width
    localparam int REM_CNT_W   = $clog2(COL_W);

    // configuration register widths
    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int ANTS_W      = 5;
    localparam int GENS_W      = 3;
    localparam int GEN_IDX_W   = 2;

    // command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ANTS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GENS_PER_TICK = 2'd3;

    // input opcodes
    localparam logic [1:0] OP_PLACE = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // headings
    localparam logic [HEAD_W-1:0] HEAD_UP    = 2'd0;
    localparam logic [HEAD_W-1:0] HEAD_RIGHT = 2'd1;
    localparam logic [HEAD_W-1:0] HEAD_DOWN  = 2'd2;
    localparam logic [HEAD_W-1:0] HEAD_LEFT  = 2'd3;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [ANT_W-1:0]  ant_slot;
        logic [COL_W-1:0]  start_x;
        logic [ROW_W-1:0]  start_y;
        logic [HEAD_W-1:0] start_heading;
    } lant_in_t;

    typedef struct packed {
        logic [COL_W-1:0] cell_x;
        logic [ROW_W-1:0] cell_y;
        logic             cell_on;
        logic [ANT_W-1:0] mover;
        logic             last_of_run;
    } lant_out_t;

    // clamped configuration as seen by the back end
    typedef struct packed {
        logic [CFG_W-1:0]  cols;
        logic [CFG_W-1:0]  rows;
        logic [ANTS_W-1:0] ants;
        logic [GENS_W-1:0] gens;
    } lant_cfg_t;

    typedef enum logic [1:0] {
        CMD_PLACE = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_CLEAR = 2'd2
    } lant_kind_t;

    // classified command held in the queue
    typedef struct packed {
        lant_kind_t        kind;
        logic [ANT_W-1:0]  slot;
        logic [COL_W-1:0]  x;
        logic [ROW_W-1:0]  y;
        logic [HEAD_W-1:0] heading;
    } lant_cmd_t;

    // one ant slot
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [HEAD_W-1:0] heading;
    } lant_ant_t;

    // back end status toward the top level
    typedef struct packed {
        logic idle;
        logic emit;
    } lant_stat_t;

endpackage

// ----- src/lant_ram.sv -----
// ----------------------------------------------------------------------------
// lant_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lant_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port, data holds between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/lant_front.sv -----
// ----------------------------------------------------------------------------
// lant_front
// Configuration registers and input classification; pushes commands to the
// queue and drops items that do nothing.
// ----------------------------------------------------------------------------
module lant_front
    import lant_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  lant_in_t             in_data,
    input  logic                 q_full,
    output logic                 q_push,
    output lant_cmd_t            q_wdata,
    output lant_cfg_t            cfg
);

    lant_cfg_t cfg_reg;
    logic [ANTS_W-1:0] ants_raw;
    logic [GENS_W-1:0] gens_raw;
    logic              in_take;
    logic              known_op;

    assign ants_raw = cfg_data[ANTS_W-1:0];
    assign gens_raw = cfg_data[GENS_W-1:0];

    // register writes, values clamped to their legal ranges on the way in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cols <= CFG_W'(MAX_COLS);
            cfg_reg.rows <= CFG_W'(MAX_ROWS);
            cfg_reg.ants <= ANTS_W'(1);
            cfg_reg.gens <= GENS_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_COLS:
                begin
                    if (cfg_data == '0)
                        cfg_reg.cols <= CFG_W'(1);
                    else if (cfg_data > CFG_W'(MAX_COLS))
                        cfg_reg.cols <= CFG_W'(MAX_COLS);
                    else
                        cfg_reg.cols <= cfg_data;
                end
                REG_GRID_ROWS:
                begin
                    if (cfg_data == '0)
                        cfg_reg.rows <= CFG_W'(1);
                    else if (cfg_data > CFG_W'(MAX_ROWS))
                        cfg_reg.rows <= CFG_W'(MAX_ROWS);
                    else
                        cfg_reg.rows <= cfg_data;
                end
                REG_ACTIVE_ANTS:
                begin
                    if (ants_raw == '0)
                        cfg_reg.ants <= ANTS_W'(1);
                    else if (ants_raw > ANTS_W'(NUM_ANTS))
                        cfg_reg.ants <= ANTS_W'(NUM_ANTS);
                    else
                        cfg_reg.ants <= ants_raw;
                end
                REG_GENS_PER_TICK:
                begin
                    if (gens_raw == '0)
                        cfg_reg.gens <= GENS_W'(1);
                    else if (gens_raw > GENS_W'(MAX_GENS))
                        cfg_reg.gens <= GENS_W'(MAX_GENS);
                    else
                        cfg_reg.gens <= gens_raw;
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

    // classify the opcode; the unknown code is taken and dropped
    always_comb
    begin
        known_op        = 1'b1;
        q_wdata.kind    = CMD_PLACE;
        q_wdata.slot    = in_data.ant_slot;
        q_wdata.x       = in_data.start_x;
        q_wdata.y       = in_data.start_y;
        q_wdata.heading = in_data.start_heading;
        unique case (in_data.opcode)
            OP_PLACE: q_wdata.kind = CMD_PLACE;
            OP_RUN:   q_wdata.kind = CMD_RUN;
            OP_CLEAR: q_wdata.kind = CMD_CLEAR;
            default:  known_op     = 1'b0;
        endcase
    end

    // input handshake against queue space
    assign in_stall = q_full;
    assign in_take  = in_valid && !q_full;
    assign q_push   = in_take && known_op;

endmodule

// ----- src/lant_queue.sv -----
// ----------------------------------------------------------------------------
// lant_queue
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module lant_queue
    import lant_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  lant_cmd_t wdata,
    output logic      full,
    input  logic      pop,
    output lant_cmd_t head,
    output logic      empty
);

    lant_cmd_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

endmodule

// ----- src/lant_rem.sv -----
// ----------------------------------------------------------------------------
// lant_rem
// Bit-serial remainder unit: folds an ant's column and row back onto the
// grid in use, one dividend bit per cycle for both coordinates.
// ----------------------------------------------------------------------------
module lant_rem
    import lant_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [COL_W-1:0] col_in,
    input  logic [ROW_W-1:0] row_in,
    input  logic [CFG_W-1:0] cols,
    input  logic [CFG_W-1:0] rows,
    output logic             done,
    output logic [COL_W-1:0] x_out,
    output logic [ROW_W-1:0] y_out
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [REM_CNT_W-1:0] cnt_reg;
    logic [COL_W-1:0]     ax_reg;
    logic [ROW_W-1:0]     ay_reg;
    logic [COL_W-1:0]     rx_reg;
    logic [ROW_W-1:0]     ry_reg;
    logic [CFG_W-1:0]     tx;
    logic [CFG_W-1:0]     ty;
    logic [CFG_W-1:0]     rx_next;
    logic [CFG_W-1:0]     ry_next;

    // one restoring step per coordinate
    always_comb
    begin
        tx      = {rx_reg, ax_reg[COL_W-1]};
        ty      = {ry_reg, ay_reg[ROW_W-1]};
        rx_next = (tx >= cols) ? tx - cols : tx;
        ry_next = (ty >= rows) ? ty - rows : ty;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + REM_CNT_W'(1);
            if (cnt_reg == REM_CNT_W'(COL_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ax_reg <= col_in;
            ay_reg <= row_in;
            rx_reg <= '0;
            ry_reg <= '0;
        end
        else if (busy_reg)
        begin
            ax_reg <= ax_reg << 1;
            ay_reg <= ay_reg << 1;
            rx_reg <= rx_next[COL_W-1:0];
            ry_reg <= ry_next[ROW_W-1:0];
        end
    end

    assign done  = done_reg;
    assign x_out = rx_reg;
    assign y_out = ry_reg;

endmodule

// ----- src/lant_back.sv -----
// ----------------------------------------------------------------------------
// lant_back
// Executes queued commands: ant table writes, grid clears and generation
// runs, each ant step a read-modify-write of one grid row.
// ----------------------------------------------------------------------------
module lant_back
    import lant_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  lant_cfg_t  cfg,
    input  lant_cmd_t  q_head,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_stall,
    output lant_out_t  out_data,
    output lant_stat_t stat
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_REM  = 5'b00100,
        S_READ = 5'b01000,
        S_MOD  = 5'b10000
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    lant_ant_t             ant_reg [NUM_ANTS];
    logic [MAX_ROWS-1:0]   row_valid_reg;
    logic [ANT_W-1:0]      ant_idx_reg;
    logic [GEN_IDX_W-1:0]  gen_idx_reg;
    logic [COL_W-1:0]      x_reg;
    logic [ROW_W-1:0]      y_reg;
    logic [HEAD_W-1:0]     head_reg;
    logic                  rv_reg;
    logic                  out_valid_reg;
    lant_out_t             out_data_reg;

    lant_ant_t             cur;
    logic                  in_range;
    logic                  rem_start;
    logic                  rem_done;
    logic [COL_W-1:0]      rem_x;
    logic [ROW_W-1:0]      rem_y;
    logic                  ram_re;
    logic                  ram_we;
    logic [MAX_COLS-1:0]   ram_rdata;
    logic [MAX_COLS-1:0]   row_cur;
    logic [MAX_COLS-1:0]   row_new;
    logic                  old_on;
    logic                  new_on;
    logic [HEAD_W-1:0]     head_new;
    logic [CFG_W-1:0]      xp;
    logic [CFG_W-1:0]      yp;
    logic [COL_W-1:0]      nx;
    logic [ROW_W-1:0]      ny;
    logic                  out_free;
    logic                  emit;
    logic                  last_ant;
    logic                  last_gen;

    // grid rows, one bit per column
    lant_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (y_reg),
        .wdata (row_new),
        .re    (ram_re),
        .raddr (y_reg),
        .rdata (ram_rdata)
    );

    // wraps an ant that sits off the grid in use
    lant_rem u_rem (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (rem_start),
        .col_in (cur.col),
        .row_in (cur.row),
        .cols   (cfg.cols),
        .rows   (cfg.rows),
        .done   (rem_done),
        .x_out  (rem_x),
        .y_out  (rem_y)
    );

    // current ant and its range check
    assign cur      = ant_reg[ant_idx_reg];
    assign in_range = ({1'b0, cur.col} < cfg.cols) && ({1'b0, cur.row} < cfg.rows);

    // cell update, turn and move
    always_comb
    begin
        row_cur          = rv_reg ? ram_rdata : '0;
        old_on           = row_cur[x_reg];
        new_on           = !old_on;
        row_new          = row_cur;
        row_new[x_reg]   = new_on;
        head_new         = old_on ? head_reg - HEAD_W'(1) : head_reg + HEAD_W'(1);
        xp               = {1'b0, x_reg} + CFG_W'(1);
        yp               = {1'b0, y_reg} + CFG_W'(1);
        nx               = x_reg;
        ny               = y_reg;
        case (head_new)
            HEAD_UP:
                ny = (y_reg == '0) ? ROW_W'(cfg.rows - CFG_W'(1)) : y_reg - ROW_W'(1);
            HEAD_RIGHT:
                nx = (xp >= cfg.cols) ? '0 : xp[COL_W-1:0];
            HEAD_DOWN:
                ny = (yp >= cfg.rows) ? '0 : yp[ROW_W-1:0];
            default:
                nx = (x_reg == '0) ? COL_W'(cfg.cols - CFG_W'(1)) : x_reg - COL_W'(1);
        endcase
    end

    // run position
    assign last_ant = ({1'b0, ant_idx_reg} == cfg.ants - ANTS_W'(1));
    assign last_gen = ({1'b0, gen_idx_reg} == cfg.gens - GENS_W'(1));

    // output slot handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = (state_reg == S_MOD) && out_free;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        rem_start  = 1'b0;
        ram_re     = 1'b0;
        ram_we     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_head.kind == CMD_RUN)
                        state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (in_range)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    rem_start  = 1'b1;
                    state_next = S_REM;
                end
            end
            S_REM:
            begin
                if (rem_done)
                    state_next = S_READ;
            end
            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                if (out_free)
                begin
                    ram_we = 1'b1;
                    if (last_ant && last_gen)
                        state_next = S_IDLE;
                    else
                        state_next = S_LOAD;
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ant_idx_reg   <= '0;
            gen_idx_reg   <= '0;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_ANTS; i++)
            begin
                ant_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // place and clear commands
            if (q_pop && (q_head.kind == CMD_PLACE))
            begin
                ant_reg[q_head.slot] <= '{col: q_head.x, row: q_head.y,
                                          heading: q_head.heading};
            end
            if (q_pop && (q_head.kind == CMD_CLEAR))
            begin
                row_valid_reg <= '0;
            end
            if (q_pop && (q_head.kind == CMD_RUN))
            begin
                ant_idx_reg <= '0;
                gen_idx_reg <= '0;
            end

            // step retire: store ant, mark row, advance
            if (emit)
            begin
                ant_reg[ant_idx_reg]  <= '{col: nx, row: ny, heading: head_new};
                row_valid_reg[y_reg]  <= 1'b1;
                if (last_ant)
                begin
                    ant_idx_reg <= '0;
                    gen_idx_reg <= gen_idx_reg + GEN_IDX_W'(1);
                end
                else
                begin
                    ant_idx_reg <= ant_idx_reg + ANT_W'(1);
                end
            end

            // output valid
            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // step datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD)
        begin
            x_reg    <= cur.col;
            y_reg    <= cur.row;
            head_reg <= cur.heading;
        end
        else if ((state_reg == S_REM) && rem_done)
        begin
            x_reg <= rem_x;
            y_reg <= rem_y;
        end
        if (state_reg == S_READ)
        begin
            rv_reg <= row_valid_reg[y_reg];
        end
        if (emit)
        begin
            out_data_reg.cell_x      <= x_reg;
            out_data_reg.cell_y      <= y_reg;
            out_data_reg.cell_on     <= new_on;
            out_data_reg.mover       <= ant_idx_reg;
            out_data_reg.last_of_run <= last_ant && last_gen;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign stat.idle = (state_reg == S_IDLE);
    assign stat.emit = emit;

endmodule

// ----- src/langton_ant_grid_step_top.sv -----
// ----------------------------------------------------------------------------
// langton_ant_grid_step_top
// Multi-ant Langton's ant on a toroidal one-bit grid: front end with
// configuration and command queue, back end stepping ants over a row memory.
//
//   channel   handshake              payload
//   --------  ---------------------  -----------------------------------------
//   cfg       cfg_we                 cfg_index, cfg_data
//   in        in_valid / in_stall    in_data (opcode, slot, start position)
//   out       out_valid / out_stall  out_data (cell, new value, mover, last)
//
// Place and clear items retire as the back end pops them in its idle state;
// a two-entry queue lets the front take items while a run is in progress.
// An ant step passes through slot read, row read and row write states when
// the ant sits on the grid, with a wrap state between slot read and row read
// when the remainder unit must first wrap it.
// Reset and clear items mark all grid rows empty at once through one valid
// bit per row; there is no clearing pass.
// A stalled output holds the step in the row write cycle until it drains.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module langton_ant_grid_step_top
    import lant_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  lant_in_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output lant_out_t            out_data
);

    lant_cfg_t  cfg;
    lant_cmd_t  q_wdata;
    lant_cmd_t  q_head;
    lant_stat_t bk_stat;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;

    // accept, classify, configuration
    lant_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata),
        .cfg       (cfg)
    );

    // decoupling queue
    lant_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .head  (q_head),
        .empty (q_empty)
    );

    // command execution
    lant_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .stat      (bk_stat)
    );

    // internal checks
    `LANT_NEVER(a_push_full, q_push && q_full, "command pushed into a full queue")
    `LANT_NEVER(a_pop_empty, q_pop && q_empty, "command popped from an empty queue")
    `LANT_ASSERT(a_pop_idle, q_pop |-> bk_stat.idle, "command taken while back end busy")
    `LANT_ASSERT(a_out_step, $rose(out_valid) |-> $past(bk_stat.emit), "result without a step")

endmodule
